// ----- rtl/nmbd_pkg.sv -----
package nmbd_pkg;

    localparam logic [2:0] DOT_RUN       = 3'd1;
    localparam logic [2:0] DASH_RUN      = 3'd3;
    localparam logic [2:0] ONES_SAT      = 3'd4;
    localparam logic [1:0] CLOSE_GAP     = 2'd3;
    localparam logic [2:0] MAX_CODE      = 3'd4;
    localparam logic [2:0] CODE_OVERFLOW = 3'd5;
    localparam logic [3:0] HEADER_BYTES  = 4'd8;
    localparam logic [3:0] NIB_LEN4_BASE = 4'hE;

    typedef struct packed {
        logic [2:0] ones_run;
        logic [1:0] zeros_run;
        logic [3:0] code_pattern;
        logic [2:0] code_length;
        logic       expect_high;
        logic [3:0] high_half;
        logic       limit_reached;
        logic       have_char;
        logic [7:0] char_value;
    } t_dec_state;

    // Start-of-stream state: everything clear except the high-nibble flag.
    localparam t_dec_state DEC_RESET = t_dec_state'({3'd0, 2'd0, 4'd0, 3'd0, 1'b1,
                                                     4'd0, 1'b0, 1'b0, 8'd0});

    function automatic t_dec_state put_nibble(t_dec_state s, logic [3:0] nib);
        t_dec_state r;
        r = s;
        if (s.expect_high) begin
            r.high_half   = nib;
            r.expect_high = 1'b0;
        end else begin
            if (!s.have_char) begin
                r.have_char  = 1'b1;
                r.char_value = {s.high_half, nib};
            end
            r.expect_high = 1'b1;
        end
        return r;
    endfunction

    function automatic t_dec_state add_element(t_dec_state s, logic dash);
        t_dec_state r;
        r = s;
        if (s.code_length < MAX_CODE) begin
            r.code_pattern = {s.code_pattern[2:0], dash};
            r.code_length  = s.code_length + 3'd1;
        end else begin
            r.code_length = CODE_OVERFLOW;
        end
        return r;
    endfunction

    function automatic t_dec_state close_element(t_dec_state s);
        t_dec_state r;
        r = s;
        if (s.ones_run == DOT_RUN) begin
            r = add_element(s, 1'b0);
        end else if (s.ones_run == DASH_RUN) begin
            r = add_element(s, 1'b1);
        end
        r.ones_run = 3'd0;
        return r;
    endfunction

    function automatic t_dec_state close_code(t_dec_state s);
        t_dec_state r;
        logic [3:0] nib;
        r   = s;
        nib = (4'd1 << s.code_length) - 4'd2 + s.code_pattern;
        if (s.code_length >= 3'd1 && s.code_length <= 3'd3) begin
            r = put_nibble(s, nib);
        end else if (s.code_length == MAX_CODE && s.code_pattern <= 4'd1) begin
            r = put_nibble(s, NIB_LEN4_BASE + s.code_pattern);
        end
        r.code_pattern = 4'd0;
        r.code_length  = 3'd0;
        return r;
    endfunction

    function automatic t_dec_state finish_stream(t_dec_state s);
        t_dec_state r;
        r = close_code(close_element(s));
        r.limit_reached = 1'b1;
        return r;
    endfunction

    function automatic t_dec_state take_bit(t_dec_state s, logic b, logic at_limit);
        t_dec_state r;
        r = s;
        if (!s.limit_reached) begin
            if (b) begin
                r.zeros_run = 2'd0;
                if (s.ones_run < ONES_SAT) begin
                    r.ones_run = s.ones_run + 3'd1;
                end
            end else if (s.ones_run != 3'd0) begin
                r = close_element(s);
                r.zeros_run = 2'd1;
            end else if (s.zeros_run < CLOSE_GAP) begin
                r.zeros_run = s.zeros_run + 2'd1;
                if (r.zeros_run == CLOSE_GAP) begin
                    r = close_code(r);
                end
            end
            if (at_limit) begin
                r = finish_stream(r);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/nibble_morse_bit_decoder_unit.sv -----
// Morse on-off keying decoder for a packed byte stream.
// Input channel (i_valid / o_ready) carries one byte per item plus a flag
// for the final byte. The first eight bytes form a little-endian bit count;
// later bytes are eight data bits each, MSB first. Output channel
// (o_valid / i_ready) carries a decoded byte and, on the item caused by the
// final byte, an end-of-stream flag and status.
// An accepted item is held in an input register and is decoded into the
// result register once that register is empty or being taken. One item
// is taken per cycle while the receiver does not stall; all eight bit
// updates of a byte are done in one pass of logic between the two registers.
// Items that complete no byte and are not final produce no result.
// When the receiver stalls, the result register holds its item and the
// input register holds one more; o_ready then falls until the result is
// taken. Reset empties both registers and returns the decoder to the start
// of a stream, as does the final byte of each stream.
module nibble_morse_bit_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_char_valid,
    output logic [7:0] o_char_value,
    output logic       o_end_of_stream,
    output logic       o_status
);

    logic                 r_in_valid;
    logic [7:0]           r_byte;
    logic                 r_last;
    logic [3:0]           r_hdr_cnt;
    logic [63:0]          r_left;
    nmbd_pkg::t_dec_state r_st;
    logic                 r_out_valid;
    logic                 r_char_valid;
    logic [7:0]           r_char_value;
    logic                 r_eos;
    logic                 r_status;

    logic                 proc_fire;
    logic [3:0]           n_hdr_cnt;
    logic [63:0]          n_left;
    nmbd_pkg::t_dec_state n_st;
    logic                 n_emit;
    logic                 n_status;

    assign proc_fire = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || proc_fire;

    always_comb begin
        nmbd_pkg::t_dec_state s;
        logic                 hdr_done;
        logic                 le8;
        logic [63:0]          hdr_word;
        hdr_done  = r_hdr_cnt[3];
        le8       = (r_left[63:4] == 60'd0) && (r_left[3:0] <= 4'd8);
        hdr_word  = {56'd0, r_byte} << {r_hdr_cnt[2:0], 3'b000};
        s         = r_st;
        s.have_char  = 1'b0;
        s.char_value = 8'd0;
        n_hdr_cnt = r_hdr_cnt;
        n_left    = r_left;
        if (!hdr_done) begin
            n_hdr_cnt = r_hdr_cnt + 4'd1;
            n_left    = r_left | hdr_word;
            if (n_hdr_cnt == nmbd_pkg::HEADER_BYTES && n_left == 64'd0) begin
                s.limit_reached = 1'b1;
            end
        end else begin
            if (!r_st.limit_reached) begin
                n_left = le8 ? 64'd0 : r_left - 64'd8;
            end
            for (int k = 0; k < 8; k++) begin
                s = nmbd_pkg::take_bit(s, r_byte[7 - k],
                                       le8 && (r_left[3:0] == 4'(k + 1)));
            end
        end
        n_status = !n_hdr_cnt[3];
        if (r_last && !s.limit_reached) begin
            s = nmbd_pkg::finish_stream(s);
        end
        n_st   = s;
        n_emit = s.have_char || r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_hdr_cnt       <= 4'd0;
            r_left          <= 64'd0;
            r_st            <= nmbd_pkg::DEC_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (proc_fire) begin
                r_out_valid <= n_emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (proc_fire) begin
                if (r_last) begin
                    r_hdr_cnt <= 4'd0;
                    r_left    <= 64'd0;
                    r_st      <= nmbd_pkg::DEC_RESET;
                end else begin
                    r_hdr_cnt <= n_hdr_cnt;
                    r_left    <= n_left;
                    r_st      <= n_st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (proc_fire && n_emit) begin
            r_char_valid <= n_st.have_char;
            r_char_value <= n_st.have_char ? n_st.char_value : 8'd0;
            r_eos        <= r_last;
            r_status     <= r_last && n_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_char_valid    = r_char_valid;
    assign o_char_value    = r_char_value;
    assign o_end_of_stream = r_eos;
    assign o_status        = r_status;

endmodule

// ----- rtl/nmbd_checker.sv -----
module nmbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_char_valid,
    input logic [7:0] o_char_value,
    input logic       o_end_of_stream,
    input logic       o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_char_value)
            && $stable(o_end_of_stream))
        else $error("Result item changed while stalled.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_mid_has_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_stream |-> o_char_valid && !o_status)
        else $error("Mid-stream result without a decoded byte.");

    a_short_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_end_of_stream && !o_char_valid)
        else $error("Short stream produced a byte.");

    a_no_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_char_value == 8'd0)
        else $error("Nonzero byte value without a decoded byte.");

endmodule

bind nibble_morse_bit_decoder_unit nmbd_checker u_nmbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_char_valid    (o_char_valid),
    .o_char_value    (o_char_value),
    .o_end_of_stream (o_end_of_stream),
    .o_status        (o_status)
);

// ----- bench/tb_nibble_morse_bit_decoder_unit.sv -----
`timescale 1ns / 100ps

module tb_nibble_morse_bit_decoder_unit;

    typedef struct packed {
        logic       char_ok;
        logic [7:0] char_byte;
        logic       stream_end;
        logic       short_hdr;
    } t_morse_char;

    class morse_char_predictor;
        logic [3:0]  hdr_seen;
        logic [63:0] bit_budget;
        logic [63:0] bits_used;
        logic [2:0]  mark_len;
        logic [1:0]  space_len;
        logic [3:0]  code_bits;
        logic [2:0]  code_len;
        logic        want_high;
        logic [3:0]  high_nib;
        logic        stopped;
        logic        byte_ready;
        logic [7:0]  byte_out;
        t_morse_char expected_chars[$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            hdr_seen   = '0;
            bit_budget = '0;
            bits_used  = '0;
            mark_len   = '0;
            space_len  = '0;
            code_bits  = '0;
            code_len   = '0;
            want_high  = 1'b1;
            high_nib   = '0;
            stopped    = 1'b0;
        endfunction

        function void emit_nibble(logic [3:0] nib);
            if (want_high) begin
                high_nib  = nib;
                want_high = 1'b0;
            end else begin
                if (!byte_ready) begin
                    byte_ready = 1'b1;
                    byte_out   = {high_nib, nib};
                end
                want_high = 1'b1;
            end
        endfunction

        function void add_mark(logic dash);
            if (code_len < nmbd_pkg::MAX_CODE) begin
                code_bits = {code_bits[2:0], dash};
                code_len  = code_len + 3'd1;
            end else begin
                code_len = nmbd_pkg::CODE_OVERFLOW;
            end
        endfunction

        function void end_mark();
            if (mark_len == nmbd_pkg::DOT_RUN) begin
                add_mark(1'b0);
            end else if (mark_len == nmbd_pkg::DASH_RUN) begin
                add_mark(1'b1);
            end
            mark_len = '0;
        endfunction

        function void end_code();
            case (code_len)
                3'd1: emit_nibble(code_bits);
                3'd2: emit_nibble(4'd2 + code_bits);
                3'd3: emit_nibble(4'd6 + code_bits);
                nmbd_pkg::MAX_CODE: begin
                    if (code_bits <= 4'd1) emit_nibble(nmbd_pkg::NIB_LEN4_BASE + code_bits);
                end
                default: ;
            endcase
            code_bits = '0;
            code_len  = '0;
        endfunction

        function void close_stream();
            end_mark();
            end_code();
            stopped = 1'b1;
        endfunction

        function void step_bit(logic b);
            if (stopped) return;
            if (b) begin
                space_len = '0;
                if (mark_len < nmbd_pkg::ONES_SAT) mark_len = mark_len + 3'd1;
            end else if (mark_len != 3'd0) begin
                end_mark();
                space_len = 2'd1;
            end else if (space_len < nmbd_pkg::CLOSE_GAP) begin
                space_len = space_len + 2'd1;
                if (space_len == nmbd_pkg::CLOSE_GAP) end_code();
            end
            bits_used = bits_used + 64'd1;
            if (bits_used == bit_budget) close_stream();
        endfunction

        function void note_byte(logic [7:0] d, logic last);
            t_morse_char r;
            logic        short_hdr;
            int          i;
            byte_ready = 1'b0;
            byte_out   = '0;
            if (hdr_seen < nmbd_pkg::HEADER_BYTES) begin
                bit_budget[8*hdr_seen +: 8] = d;
                hdr_seen = hdr_seen + 4'd1;
                if (hdr_seen == nmbd_pkg::HEADER_BYTES && bit_budget == 64'd0) begin
                    stopped = 1'b1;
                end
            end else begin
                for (i = 7; i >= 0; i--) step_bit(d[i]);
            end
            if (last) begin
                short_hdr = (hdr_seen < nmbd_pkg::HEADER_BYTES);
                if (!stopped) close_stream();
                r.char_ok    = byte_ready;
                r.char_byte  = byte_ready ? byte_out : 8'd0;
                r.stream_end = 1'b1;
                r.short_hdr  = short_hdr;
                expected_chars = {expected_chars, r};
                restart();
            end else if (byte_ready) begin
                r.char_ok    = 1'b1;
                r.char_byte  = byte_out;
                r.stream_end = 1'b0;
                r.short_hdr  = 1'b0;
                expected_chars = {expected_chars, r};
            end
        endfunction

        function void report(string what, t_morse_char want, t_morse_char got);
            errors++;
            if (errors <= 10) begin
                $display({"%t %s: expected ok=%0b byte=%02h end=%0b st=%0b,",
                          " got ok=%0b byte=%02h end=%0b st=%0b"},
                         $time, what, want.char_ok, want.char_byte, want.stream_end,
                         want.short_hdr, got.char_ok, got.char_byte, got.stream_end,
                         got.short_hdr);
            end
        endfunction

        function void check_char(logic ok, logic [7:0] val, logic eos, logic st);
            t_morse_char got;
            t_morse_char want;
            got.char_ok    = ok;
            got.char_byte  = val;
            got.stream_end = eos;
            got.short_hdr  = st;
            if (expected_chars.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_chars.pop_front();
            if (got.char_ok !== want.char_ok || got.char_byte !== want.char_byte ||
                got.stream_end !== want.stream_end || got.short_hdr !== want.short_hdr) begin
                report("mismatch", want, got);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_ready;
    logic       o_char_valid;
    logic [7:0] o_char_value;
    logic       o_end_of_stream;
    logic       o_status;

    morse_char_predictor chars = new();
    logic [7:0] stream_q[$];
    int items_sent   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_req  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    nibble_morse_bit_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_char_valid    (o_char_valid),
        .o_char_value    (o_char_value),
        .o_end_of_stream (o_end_of_stream),
        .o_status        (o_status)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                chars.check_char(o_char_valid, o_char_value, o_end_of_stream, o_status);
            end
            if (i_valid && o_ready) chars.note_byte(i_data_byte, i_last_byte);
        end
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_seen != rx_hold_req) begin
                rx_hold_seen = rx_hold_req;
                rx_hold_left = 120;
            end
            if (rx_hold_left > 0) begin
                i_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [7:0] d, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_stream();
        int k;
        for (k = 0; k < stream_q.size(); k++) send_item(stream_q[k], k == stream_q.size() - 1);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (chars.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic build_coded_stream(input int n_codes);
        bit          marks[$];
        int          k;
        int          e;
        int          nib;
        int          len;
        int          pat;
        int          run;
        int          gap;
        int          total;
        int          sel;
        logic [63:0] budget;
        logic [7:0]  b;
        marks = {};
        for (k = 0; k < n_codes; k++) begin
            nib = $urandom_range(15);
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(6, 4);
                pat = $urandom;
            end else if (nib < 2) begin
                len = 1;
                pat = nib;
            end else if (nib < 6) begin
                len = 2;
                pat = nib - 2;
            end else if (nib < 14) begin
                len = 3;
                pat = nib - 6;
            end else begin
                len = 4;
                pat = nib - 14;
            end
            for (e = len - 1; e >= 0; e--) begin
                if (e != len - 1) begin
                    marks = {marks, 1'b0};
                    if ($urandom_range(9) == 0) marks = {marks, 1'b0};
                end
                run = ((pat >> e) & 1) ? 3 : 1;
                if ($urandom_range(19) == 0) run = ($urandom_range(1) == 0) ? 2 : 5;
                repeat (run) marks = {marks, 1'b1};
            end
            gap = ($urandom_range(4) == 0) ? $urandom_range(9, 4) : 3;
            if (k == n_codes - 1 && $urandom_range(3) == 0) gap = 0;
            repeat (gap) marks = {marks, 1'b0};
        end
        total = marks.size();
        sel   = $urandom_range(9);
        if (sel <= 4) budget = 64'(total);
        else if (sel <= 6) budget = 64'($urandom_range(total));
        else if (sel == 7) budget = {$urandom, $urandom};
        else budget = 64'(total) + 64'($urandom_range(12));
        while (marks.size() % 8 != 0) marks = {marks, 1'($urandom_range(1))};
        stream_q = {};
        for (k = 0; k < 8; k++) stream_q = {stream_q, budget[8*k +: 8]};
        for (k = 0; k < marks.size() / 8; k++) begin
            for (e = 0; e < 8; e++) b[7-e] = marks[8*k + e];
            stream_q = {stream_q, b};
        end
    endtask

    task automatic build_noise_stream(input logic short_hdr);
        int k;
        int n;
        stream_q = {};
        if (short_hdr) begin
            n = $urandom_range(7, 1);
            for (k = 0; k < n; k++) stream_q = {stream_q, 8'($urandom_range(255))};
        end else begin
            for (k = 0; k < 8; k++) begin
                if (k == 0 || $urandom_range(2) == 0) begin
                    stream_q = {stream_q, 8'($urandom_range(255))};
                end else begin
                    stream_q = {stream_q, 8'h00};
                end
            end
            n = $urandom_range(14, 1);
            for (k = 0; k < n; k++) stream_q = {stream_q, 8'($urandom_range(255))};
        end
    endtask

    task automatic send_random_streams(input int target);
        int r;
        while (items_sent < target) begin
            r = $urandom_range(9);
            if (r == 0) build_noise_stream(1'b1);
            else if (r <= 2) build_noise_stream(1'b0);
            else build_coded_stream($urandom_range(8));
            send_stream();
        end
    endtask

    task automatic stall_receiver_burst();
        int keep_tx;
        keep_tx     = tx_idle_pct;
        tx_idle_pct = 0;
        rx_hold_req++;
        build_coded_stream(10);
        send_stream();
        build_coded_stream(10);
        send_stream();
        tx_idle_pct = keep_tx;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'h00;
        i_last_byte = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        stream_q = {8'h55};
        send_stream();
        stream_q = {8'hFF, 8'h00, 8'h80};
        send_stream();
        stream_q = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00};
        send_stream();
        stream_q = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h8A, 8'hA8, 8'hE2, 8'h3F, 8'h80};
        send_stream();
        drain_results();

        tx_idle_pct = 28;
        rx_idle_pct = 78;
        send_random_streams(items_sent + 60);
        stall_receiver_burst();
        drain_results();
        send_random_streams(270);
        drain_results();

        tx_idle_pct = 78;
        rx_idle_pct = 28;
        send_random_streams(540);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_streams(800);
        drain_results();

        if (chars.errors == 0 && chars.pending() == 0) begin
            $display("tb_nibble_morse_bit_decoder_unit: done, clean");
        end else begin
            $display("tb_nibble_morse_bit_decoder_unit: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_nibble_morse_bit_decoder_unit: done, errors");
        $finish;
    end

endmodule

// ----- nibble_morse_bit_decoder_unit.f -----
rtl/nmbd_pkg.sv
rtl/nibble_morse_bit_decoder_unit.sv
rtl/nmbd_checker.sv
bench/tb_nibble_morse_bit_decoder_unit.sv
